FILE: src/mips_lb_sb_add_sub_core_top_defines.svh
// Assertion macros used by the core's top-level RTL file.
`ifndef MIPS_LB_SB_ADD_SUB_CORE_TOP_DEFINES_SVH
`define MIPS_LB_SB_ADD_SUB_CORE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MLSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define MLSA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mlsa_pkg.sv
// Shared constants, types and functions of the MIPS lb/sb/add/sub core.
package mlsa_pkg;

   localparam int MEM_DEPTH      = 1024;
   localparam int INSTR_W        = 32;
   localparam int DATA_W         = 32;
   localparam int REG_ADDR_W     = 5;
   localparam int BYTE_W         = 8;
   localparam int STATUS_W       = 2;
   localparam int OPC_W          = 6;
   localparam int MEM_ADDR_OUT_W = 10;
   localparam int RSP_DATA_W     = 64;

   localparam logic [OPC_W-1:0] OPC_RTYPE = 6'h00;
   localparam logic [OPC_W-1:0] OPC_LB    = 6'h20;
   localparam logic [OPC_W-1:0] OPC_SB    = 6'h28;
   localparam logic [OPC_W-1:0] FN_ADD    = 6'h20;
   localparam logic [OPC_W-1:0] FN_SUB    = 6'h22;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOP    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_OP = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_FN = 2'd3;

   localparam logic [DATA_W-1:0] REG_RESET_BASE = 32'h0000_0100;

   typedef struct packed {
      logic                  en;
      logic [REG_ADDR_W-1:0] addr;
      logic [DATA_W-1:0]     data;
   } rf_wr_type;

   function automatic logic [DATA_W-1:0] reg_reset_value(input logic [REG_ADDR_W-1:0] idx);
      logic [DATA_W-1:0] val;
      val = (idx == '0) ? '0 : REG_RESET_BASE + DATA_W'(idx);
      return val;
   endfunction

endpackage

FILE: src/mlsa_regfile.sv
// Register file memory with two registered read ports, reset valid bits and write bypass.
module mlsa_regfile (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [mlsa_pkg::REG_ADDR_W-1:0]  rd_a_addr,
   input  logic [mlsa_pkg::REG_ADDR_W-1:0]  rd_b_addr,
   input  mlsa_pkg::rf_wr_type              wr,
   output logic [mlsa_pkg::DATA_W-1:0]      rd_a_data,
   output logic [mlsa_pkg::DATA_W-1:0]      rd_b_data
);

   localparam int REG_COUNT = 1 << mlsa_pkg::REG_ADDR_W;

   logic [mlsa_pkg::DATA_W-1:0]     mem [REG_COUNT];
   logic [REG_COUNT-1:0]            vld_ff;
   logic [mlsa_pkg::DATA_W-1:0]     rd_a_mem_ff;
   logic [mlsa_pkg::DATA_W-1:0]     rd_b_mem_ff;
   logic                            rd_a_vld_ff;
   logic                            rd_b_vld_ff;
   logic [mlsa_pkg::REG_ADDR_W-1:0] rd_a_addr_ff;
   logic [mlsa_pkg::REG_ADDR_W-1:0] rd_b_addr_ff;
   mlsa_pkg::rf_wr_type             wb_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_mem_ff  <= mem[rd_a_addr];
      rd_b_mem_ff  <= mem[rd_b_addr];
      rd_a_vld_ff  <= vld_ff[rd_a_addr];
      rd_b_vld_ff  <= vld_ff[rd_b_addr];
      rd_a_addr_ff <= rd_a_addr;
      rd_b_addr_ff <= rd_b_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         wb_ff.en <= 1'b0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
         wb_ff           <= wr;
      end
   end

   always_comb begin
      if (wb_ff.en && wb_ff.addr == rd_a_addr_ff) begin
         rd_a_data = wb_ff.data;
      end else if (rd_a_vld_ff) begin
         rd_a_data = rd_a_mem_ff;
      end else begin
         rd_a_data = mlsa_pkg::reg_reset_value(rd_a_addr_ff);
      end
      if (wb_ff.en && wb_ff.addr == rd_b_addr_ff) begin
         rd_b_data = wb_ff.data;
      end else if (rd_b_vld_ff) begin
         rd_b_data = rd_b_mem_ff;
      end else begin
         rd_b_data = mlsa_pkg::reg_reset_value(rd_b_addr_ff);
      end
   end

endmodule

FILE: src/mlsa_ea_mod.sv
// Registered reduction of the effective address sum modulo the data memory depth.
module mlsa_ea_mod #(
   parameter int MEM_DEPTH = mlsa_pkg::MEM_DEPTH
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [mlsa_pkg::DATA_W-1:0]   sum_in,
   output logic [$clog2(MEM_DEPTH)-1:0]  ea
);

   localparam int ADDR_W = $clog2(MEM_DEPTH);
   localparam bit IS_POW2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;

   logic [mlsa_pkg::DATA_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

   generate
      if (IS_POW2) begin : g_pow2
         assign ea = sum_ff[ADDR_W-1:0];
      end else begin : g_recip
         localparam int          SH    = mlsa_pkg::DATA_W + ADDR_W;
         localparam int          PRD_W = 66;
         localparam int          Q_W   = PRD_W - SH;
         localparam logic [63:0] RECIP = (64'd1 << SH) / 64'(MEM_DEPTH);

         logic [PRD_W-1:0]            prod;
         logic [Q_W-1:0]              q_ff;
         logic [mlsa_pkg::DATA_W-1:0] qd;
         logic [mlsa_pkg::DATA_W-1:0] rem;
         logic [mlsa_pkg::DATA_W-1:0] rem_adj;

         assign prod = PRD_W'(sum_in) * PRD_W'(RECIP[32:0]);

         always_ff @(posedge clock) begin
            if (en) begin
               q_ff <= prod[PRD_W-1:SH];
            end
         end

         assign qd      = mlsa_pkg::DATA_W'(q_ff) * mlsa_pkg::DATA_W'(MEM_DEPTH);
         assign rem     = sum_ff - qd;
         assign rem_adj = (rem >= mlsa_pkg::DATA_W'(MEM_DEPTH)) ?
                          rem - mlsa_pkg::DATA_W'(MEM_DEPTH) : rem;
         assign ea      = rem_adj[ADDR_W-1:0];
      end
   endgenerate

endmodule

FILE: src/mips_lb_sb_add_sub_core_top.sv
// Top level of the MIPS lb/sb/add/sub core: five-stage pipeline around two memories.
// Path: an accepted instruction word moves through P1, P2, P3 and P4 to the result register.
// Throughput: one instruction per cycle unless rsp_tready or a load hazard stalls; a reader of
// an lb target one or two slots ahead stalls in P1, since load data leaves the data memory last.
// Reset: synchronous; registers read 0x100+i (r0 reads 0) through per-register valid bits,
// and the data memory is filled with i modulo 256 while req_tready is held low.
`include "mips_lb_sb_add_sub_core_top_defines.svh"

module mips_lb_sb_add_sub_core_top #(
   parameter int MEM_DEPTH = mlsa_pkg::MEM_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mlsa_pkg::INSTR_W-1:0]        req_tdata,   // instruction[31:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // reg_written[0], dest_reg[5:1], dest_value[37:6], mem_written[38],
   // mem_address[48:39], mem_byte[56:49], zero[63:57]
   output logic [mlsa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [mlsa_pkg::STATUS_W-1:0]       rsp_tuser    // status[1:0]
);

   localparam int ADDR_W = $clog2(MEM_DEPTH);
   localparam int DW     = mlsa_pkg::DATA_W;
   localparam int RW     = mlsa_pkg::REG_ADDR_W;
   localparam int BW     = mlsa_pkg::BYTE_W;

   typedef struct packed {
      logic [mlsa_pkg::STATUS_W-1:0] status;
      logic                          rw;
      logic [RW-1:0]                 dreg;
      logic [DW-1:0]                 val;
      logic                          lb;
      logic                          sb;
      logic [BW-1:0]                 sbyte;
   } stage_type;

   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   logic                           p1_vld_ff;
   logic [mlsa_pkg::INSTR_W-1:0]   p1_instr_ff;
   logic                           p2_vld_ff;
   logic                           p3_vld_ff;
   logic                           p4_vld_ff;
   stage_type                      p1_in;
   stage_type                      p2_ff;
   stage_type                      p3_ff;
   stage_type                      p4_ff;
   logic [DW-1:0]                  p2_sum_ff;
   logic [DW-1:0]                  p1_sum_in;
   logic [ADDR_W-1:0]              p3_ea;
   logic [ADDR_W-1:0]              p4_ea_ff;
   logic [BW-1:0]                  mem_rd_ff;
   logic [BW-1:0]                  dmem [MEM_DEPTH];

   logic                           adv;
   logic                           hazard;
   logic                           p1_go;
   logic                           req_accept;

   logic [mlsa_pkg::OPC_W-1:0]     p1_op;
   logic [mlsa_pkg::OPC_W-1:0]     p1_fn;
   logic [RW-1:0]                  p1_rs;
   logic [RW-1:0]                  p1_rt;
   logic [RW-1:0]                  p1_rd;
   logic [15:0]                    p1_imm;
   logic                           p1_uses_rs;
   logic                           p1_uses_rt;
   logic                           hit2;
   logic                           hit3;

   logic [RW-1:0]                  rd_a_addr;
   logic [RW-1:0]                  rd_b_addr;
   logic [DW-1:0]                  rf_a;
   logic [DW-1:0]                  rf_b;
   logic [DW-1:0]                  op_a;
   logic [DW-1:0]                  op_b;
   logic [DW-1:0]                  p4_ld_val;
   logic [DW-1:0]                  p4_val;
   mlsa_pkg::rf_wr_type            rf_wr;

   logic                           dm_we;
   logic [ADDR_W-1:0]              dm_waddr;
   logic [BW-1:0]                  dm_wdata;

   logic [mlsa_pkg::MEM_ADDR_OUT_W-1:0] out_maddr;
   logic [BW-1:0]                       out_mbyte;
   logic                                rsp_vld_ff;
   logic [mlsa_pkg::RSP_DATA_W-1:0]     rsp_data_ff;
   logic [mlsa_pkg::STATUS_W-1:0]       rsp_user_ff;

   // fill pass over the data memory after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         if (clr_cnt_ff == ADDR_W'(MEM_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // flow control
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign p1_go      = adv && !hazard;
   assign req_tready = !clr_busy_ff && (!p1_vld_ff || p1_go);
   assign req_accept = req_tvalid && req_tready;

   // decode
   assign p1_op      = p1_instr_ff[31:26];
   assign p1_rs      = p1_instr_ff[25:21];
   assign p1_rt      = p1_instr_ff[20:16];
   assign p1_rd      = p1_instr_ff[15:11];
   assign p1_fn      = p1_instr_ff[5:0];
   assign p1_imm     = p1_instr_ff[15:0];
   assign p1_uses_rs = p1_instr_ff != '0;
   assign p1_uses_rt = p1_op == mlsa_pkg::OPC_RTYPE || p1_op == mlsa_pkg::OPC_SB;

   // hold on a load whose data is not out of the memory yet
   assign hit2 = p2_vld_ff && p2_ff.lb && p2_ff.rw &&
                 ((p1_uses_rs && p2_ff.dreg == p1_rs) || (p1_uses_rt && p2_ff.dreg == p1_rt));
   assign hit3 = p3_vld_ff && p3_ff.lb && p3_ff.rw &&
                 ((p1_uses_rs && p3_ff.dreg == p1_rs) || (p1_uses_rt && p3_ff.dreg == p1_rt));
   assign hazard = p1_vld_ff && (hit2 || hit3);

   // register file, read again every cycle while the word in P1 holds
   assign rd_a_addr = req_accept ? req_tdata[25:21] : p1_rs;
   assign rd_b_addr = req_accept ? req_tdata[20:16] : p1_rt;

   mlsa_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .wr        (rf_wr),
      .rd_a_data (rf_a),
      .rd_b_data (rf_b)
   );

   assign p4_ld_val = {{(DW - BW){mem_rd_ff[BW-1]}}, mem_rd_ff};
   assign p4_val    = p4_ff.lb ? p4_ld_val : p4_ff.val;

   always_comb begin
      if (p2_vld_ff && p2_ff.rw && p2_ff.dreg == p1_rs) begin
         op_a = p2_ff.val;
      end else if (p3_vld_ff && p3_ff.rw && p3_ff.dreg == p1_rs) begin
         op_a = p3_ff.val;
      end else if (p4_vld_ff && p4_ff.rw && p4_ff.dreg == p1_rs) begin
         op_a = p4_val;
      end else begin
         op_a = rf_a;
      end
      if (p2_vld_ff && p2_ff.rw && p2_ff.dreg == p1_rt) begin
         op_b = p2_ff.val;
      end else if (p3_vld_ff && p3_ff.rw && p3_ff.dreg == p1_rt) begin
         op_b = p3_ff.val;
      end else if (p4_vld_ff && p4_ff.rw && p4_ff.dreg == p1_rt) begin
         op_b = p4_val;
      end else begin
         op_b = rf_b;
      end
   end

   // execute
   always_comb begin
      p1_in.status = mlsa_pkg::ST_DONE;
      p1_in.rw     = 1'b0;
      p1_in.dreg   = '0;
      p1_in.val    = (p1_fn == mlsa_pkg::FN_SUB) ? op_a - op_b : op_a + op_b;
      p1_in.lb     = 1'b0;
      p1_in.sb     = 1'b0;
      p1_in.sbyte  = op_b[BW-1:0];
      p1_sum_in    = op_a + {{(DW - 16){p1_imm[15]}}, p1_imm};
      if (p1_instr_ff == '0) begin
         p1_in.status = mlsa_pkg::ST_NOP;
      end else begin
         case (p1_op)
            mlsa_pkg::OPC_RTYPE: begin
               if (p1_fn == mlsa_pkg::FN_ADD || p1_fn == mlsa_pkg::FN_SUB) begin
                  p1_in.rw   = p1_rd != '0;
                  p1_in.dreg = p1_rd;
               end else begin
                  p1_in.status = mlsa_pkg::ST_BAD_FN;
               end
            end
            mlsa_pkg::OPC_LB: begin
               p1_in.lb   = 1'b1;
               p1_in.rw   = p1_rt != '0;
               p1_in.dreg = p1_rt;
            end
            mlsa_pkg::OPC_SB: begin
               p1_in.sb = 1'b1;
            end
            default: begin
               p1_in.status = mlsa_pkg::ST_BAD_OP;
            end
         endcase
      end
      if (!p1_in.rw) begin
         p1_in.dreg = '0;
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            p1_vld_ff <= req_tvalid;
         end
         if (adv) begin
            p2_vld_ff <= p1_vld_ff && !hazard;
            p3_vld_ff <= p2_vld_ff;
            p4_vld_ff <= p3_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         p1_instr_ff <= req_tdata;
      end
      if (adv) begin
         p2_ff     <= p1_in;
         p2_sum_ff <= p1_sum_in;
         p3_ff     <= p2_ff;
         p4_ff     <= p3_ff;
         p4_ea_ff  <= p3_ea;
      end
   end

   mlsa_ea_mod #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_ea_mod (
      .clock  (clock),
      .en     (adv),
      .sum_in (p2_sum_ff),
      .ea     (p3_ea)
   );

   // data memory: store from P3, load data lands in P4
   assign dm_we    = clr_busy_ff || (adv && p3_vld_ff && p3_ff.sb);
   assign dm_waddr = clr_busy_ff ? clr_cnt_ff : p3_ea;
   assign dm_wdata = clr_busy_ff ? BW'(clr_cnt_ff) : p3_ff.sbyte;

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dmem[dm_waddr] <= dm_wdata;
      end
      if (adv) begin
         mem_rd_ff <= dmem[p3_ea];
      end
   end

   // write back and result word
   assign rf_wr.en   = adv && p4_vld_ff && p4_ff.rw;
   assign rf_wr.addr = p4_ff.dreg;
   assign rf_wr.data = p4_val;

   assign out_maddr = (p4_ff.lb || p4_ff.sb) ?
                      mlsa_pkg::MEM_ADDR_OUT_W'(p4_ea_ff) : '0;
   assign out_mbyte = p4_ff.lb ? mem_rd_ff : (p4_ff.sb ? p4_ff.sbyte : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= p4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_user_ff <= p4_ff.status;
         rsp_data_ff <= {7'b0, out_mbyte, out_maddr, p4_ff.sb,
                         (p4_ff.rw ? p4_val : DW'(0)), p4_ff.dreg, p4_ff.rw};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `MLSA_ASSERT_IMP(a_no_accept_in_clear, clock, reset, clr_busy_ff, !req_tready, "word accepted during memory clear")
   `MLSA_ASSERT_IMP(a_no_r0_write, clock, reset, rf_wr.en, rf_wr.addr != '0, "write to register zero")
   `MLSA_ASSERT_NXT(a_hazard_holds_p1, clock, reset, hazard, p1_vld_ff && $stable(p1_instr_ff), "load hazard did not hold P1")
   `MLSA_ASSERT_IMP(a_store_after_clear, clock, reset, adv && p3_vld_ff && p3_ff.sb, !clr_busy_ff, "store during memory clear")

endmodule
